>>> rtl/core/ccsm_pkg.sv
// Shared types, codes and sizes for the charger connector state machine.
package ccsm_pkg;

  localparam int NUM_GUNS = 2;
  localparam int GUN_IDX_W = (NUM_GUNS > 1) ? $clog2(NUM_GUNS) : 1;

  typedef enum logic [3:0] {
    ST_SELF_CHECK  = 4'd0,
    ST_AVAILABLE   = 4'd1,
    ST_PREPARING   = 4'd2,
    ST_CHARGING    = 4'd3,
    ST_EV_SUSP     = 4'd4,
    ST_EVSE_SUSP   = 4'd5,
    ST_FINISHING   = 4'd6,
    ST_RESERVED    = 4'd7,
    ST_UNAVAILABLE = 4'd8,
    ST_FAULTED     = 4'd9
  } work_state_t;

  // BMS phase codes; codes 1 and 7 are unnamed and are compared as they stand
  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_CABLE_CK = 3'd2;
  localparam logic [2:0] PH_CHARGE   = 3'd3;
  localparam logic [2:0] PH_FINISH   = 3'd4;
  localparam logic [2:0] PH_FAULT_AB = 3'd5;
  localparam logic [2:0] PH_FAULT_C  = 3'd6;

  typedef enum logic [2:0] {
    RS_NONE     = 3'd0,
    RS_FAULT    = 3'd1,
    RS_PLUG_IN  = 3'd2,
    RS_PLUG_OUT = 3'd3,
    RS_START    = 3'd4
  } status_reason_t;

  typedef enum logic [2:0] {
    SR_DEFAULT     = 3'd0,
    SR_LOCK        = 3'd1,
    SR_CAR         = 3'd2,
    SR_EMERGENCY   = 3'd3,
    SR_CAR_RUNNING = 3'd4,
    SR_DOOR        = 3'd5,
    SR_FAULT       = 3'd6
  } stop_reason_t;

  typedef enum logic [2:0] {
    LED_GREEN  = 3'd0,
    LED_BLUE   = 3'd1,
    LED_YELLOW = 3'd2,
    LED_RED    = 3'd3,
    LED_KEEP   = 3'd4
  } led_color_t;

  typedef enum logic [1:0] {
    PAT_STEADY  = 2'd0,
    PAT_BLINK   = 2'd1,
    PAT_BREATHE = 2'd2
  } led_pattern_t;

  typedef struct packed {
    logic       gun;
    logic       fault_present;
    logic       plugged;
    logic [2:0] bms_phase;
    logic       ev_paused;
    logic       order_running;
    logic       lock_check_ok;
    logic       lock_fault;
    logic       estop_fault;
    logic       outside_volt_high;
    logic       door_open;
  } ccsm_item_t;

  typedef struct packed {
    logic           gun_out;
    work_state_t    work_state;
    logic           state_changed;
    status_reason_t status_reason;
    logic           stop_order;
    stop_reason_t   stop_reason;
    logic           clear_auth;
    logic           return_to_wait;
    logic           cst_fault;
    led_color_t     led_color;
    led_pattern_t   led_pattern;
  } ccsm_result_t;

  // write request from the rule logic to the state store
  typedef struct packed {
    logic                 en;
    logic [GUN_IDX_W-1:0] idx;
    work_state_t          state;
  } ccsm_wr_t;

endpackage

>>> rtl/core/charger_connector_state_machine_core.sv
// Top level: input register, connector rule logic and result register.
// One connector tick is accepted per clock while in_stall is low. An accepted
// tick loads the input register and then, once the result side can take it,
// the result register. Throughput is one tick per cycle unless stalled, set by
// the single rule-logic pass that reads and writes the per-connector state in
// the same cycle, so back-to-back ticks for one connector always see the latest
// state.
// in_stall rises only when both the input register and the result register
// hold a beat and the result side is stalled. No clearing pass is needed:
// reset puts every connector in self-check at once.
module charger_connector_state_machine_core import ccsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       gun,
  input  logic       fault_present,
  input  logic       plugged,
  input  logic [2:0] bms_phase,
  input  logic       ev_paused,
  input  logic       order_running,
  input  logic       lock_check_ok,
  input  logic       lock_fault,
  input  logic       estop_fault,
  input  logic       outside_volt_high,
  input  logic       door_open,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       gun_out,
  output logic [3:0] work_state,
  output logic       state_changed,
  output logic [2:0] status_reason,
  output logic       stop_order,
  output logic [2:0] stop_reason,
  output logic       clear_auth,
  output logic       return_to_wait,
  output logic       cst_fault,
  output logic [2:0] led_color,
  output logic [1:0] led_pattern
);

  ccsm_item_t   item;
  logic         item_valid;
  ccsm_result_t result;
  ccsm_result_t res_comb;
  work_state_t  cur_state;
  work_state_t  state_next;
  ccsm_wr_t     wr;
  logic         advance;
  logic         in_range;
  logic [GUN_IDX_W-1:0] idx;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;
  assign in_range = (int'(item.gun) < NUM_GUNS);
  assign idx      = GUN_IDX_W'(item.gun);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{gun: gun, fault_present: fault_present, plugged: plugged,
                bms_phase: bms_phase, ev_paused: ev_paused,
                order_running: order_running, lock_check_ok: lock_check_ok,
                lock_fault: lock_fault, estop_fault: estop_fault,
                outside_volt_high: outside_volt_high, door_open: door_open};
    end
  end

  ccsm_state_store u_store (
    .clk         (clk),
    .rst         (rst),
    .rd_idx      (idx),
    .rd_in_range (in_range),
    .rd_state    (cur_state),
    .wr          (wr)
  );

  ccsm_rules u_rules (
    .item       (item),
    .in_range   (in_range),
    .cur_state  (cur_state),
    .state_next (state_next),
    .res        (res_comb)
  );

  // commit the state only when the beat moves into the result register
  assign wr.en    = item_valid && advance && in_range;
  assign wr.idx   = idx;
  assign wr.state = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= res_comb;
    end
  end

  assign gun_out        = result.gun_out;
  assign work_state     = result.work_state;
  assign state_changed  = result.state_changed;
  assign status_reason  = result.status_reason;
  assign stop_order     = result.stop_order;
  assign stop_reason    = result.stop_reason;
  assign clear_auth     = result.clear_auth;
  assign return_to_wait = result.return_to_wait;
  assign cst_fault      = result.cst_fault;
  assign led_color      = result.led_color;
  assign led_pattern    = result.led_pattern;

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("pending input beat lost while result side stalled");

  a_stop_reason_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stop_order |-> stop_reason == SR_DEFAULT)
    else $error("stop reason set without stop request");

  a_cst_to_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && cst_fault |-> work_state == ST_FAULTED && state_changed)
    else $error("CST fault request without move to faulted");

  a_keep_led_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_color == LED_KEEP |-> led_pattern == PAT_STEADY)
    else $error("LED pattern set while color is left unchanged");

endmodule

>>> rtl/core/ccsm_state_store.sv
// Per-connector work state registers with one read and one write port.
module ccsm_state_store import ccsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [GUN_IDX_W-1:0] rd_idx,
  input  logic                 rd_in_range,
  output work_state_t          rd_state,
  input  ccsm_wr_t             wr
);

  work_state_t state [NUM_GUNS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_GUNS; i++) begin
        state[i] <= ST_SELF_CHECK;
      end
    end else if (wr.en) begin
      for (int i = 0; i < NUM_GUNS; i++) begin
        if (wr.idx == GUN_IDX_W'(i)) begin
          state[i] <= wr.state;
        end
      end
    end
  end

  // out-of-range connectors read as self-check; their results ignore it anyway
  assign rd_state = rd_in_range ? state[rd_idx] : ST_SELF_CHECK;

endmodule

>>> rtl/core/ccsm_rules.sv
// Transition rules, request outputs and LED decode for one connector tick.
module ccsm_rules import ccsm_pkg::*; (
  input  ccsm_item_t   item,
  input  logic         in_range,
  input  work_state_t  cur_state,
  output work_state_t  state_next,
  output ccsm_result_t res
);

  logic       flt;
  logic       plug;
  logic       pause;
  logic       order;
  logic [2:0] ph;

  assign flt   = item.fault_present;
  assign plug  = item.plugged;
  assign pause = item.ev_paused;
  assign order = item.order_running;
  assign ph    = item.bms_phase;

  // next state
  always_comb begin
    state_next = cur_state;
    case (cur_state)
      ST_AVAILABLE: begin
        if (flt) state_next = ST_FAULTED;
        else if (plug) state_next = ST_PREPARING;
      end
      ST_PREPARING: begin
        if (flt) state_next = ST_FAULTED;
        else if (!plug) state_next = ST_AVAILABLE;
        else if (ph >= PH_CABLE_CK && ph != PH_FAULT_AB) state_next = ST_EVSE_SUSP;
      end
      ST_CHARGING: begin
        if (flt) state_next = ST_FAULTED;
        else if (pause) state_next = ST_EV_SUSP;
        else if (ph == PH_FINISH) state_next = ST_FINISHING;
        else if (ph == PH_FAULT_AB) state_next = ST_FAULTED;
        else if (ph == PH_FAULT_C) state_next = ST_EVSE_SUSP;
      end
      ST_EV_SUSP: begin
        if (flt) state_next = ST_FAULTED;
        else if (!pause) state_next = ST_CHARGING;
        else if (ph == PH_FINISH) state_next = ST_FINISHING;
        else if (ph == PH_FAULT_AB) state_next = ST_FAULTED;
        else if (ph == PH_FAULT_C) state_next = ST_EVSE_SUSP;
      end
      ST_EVSE_SUSP: begin
        if (flt) state_next = ST_FAULTED;
        else if (ph == PH_WAIT) state_next = ST_AVAILABLE;
        else if (ph == PH_CHARGE) state_next = ST_CHARGING;
        else if (ph == PH_FINISH) state_next = ST_FINISHING;
        else if (ph == PH_FAULT_AB) state_next = ST_FAULTED;
      end
      ST_FINISHING: begin
        if (flt) state_next = ST_FAULTED;
        else if (!plug) state_next = ST_AVAILABLE;
      end
      ST_RESERVED, ST_UNAVAILABLE: state_next = cur_state;
      ST_FAULTED: begin
        if (!flt) begin
          if (plug) state_next = (ph != PH_FINISH) ? ST_PREPARING : ST_FINISHING;
          else state_next = ST_AVAILABLE;
        end
      end
      default: begin
        if (item.lock_check_ok) state_next = ST_AVAILABLE;
      end
    endcase
  end

  // requests, status reason and LED
  always_comb begin
    res = '0;
    res.gun_out       = item.gun;
    res.work_state    = state_next;
    res.state_changed = (state_next != cur_state);
    res.status_reason = RS_NONE;
    res.stop_reason   = SR_DEFAULT;
    res.led_color     = LED_KEEP;
    res.led_pattern   = PAT_STEADY;

    case (cur_state)
      ST_AVAILABLE: begin
        res.stop_order = order;
        if (order && item.lock_fault) res.stop_reason = SR_LOCK;
        if (flt) res.status_reason = RS_FAULT;
        else if (plug) res.status_reason = RS_PLUG_IN;
      end
      ST_PREPARING: begin
        if (flt) res.status_reason = RS_FAULT;
        else if (!plug) res.status_reason = RS_PLUG_OUT;
      end
      ST_CHARGING: begin
        if (flt) begin
          res.cst_fault     = 1'b1;
          res.status_reason = RS_FAULT;
        end else if (!pause) begin
          if (ph == PH_FINISH) res.clear_auth = 1'b1;
          else if (ph == PH_FAULT_AB) res.status_reason = RS_FAULT;
        end
      end
      ST_EV_SUSP: begin
        if (flt) res.status_reason = RS_FAULT;
        else if (pause) begin
          if (ph == PH_FINISH) res.clear_auth = 1'b1;
          else if (ph == PH_FAULT_AB) res.status_reason = RS_FAULT;
        end
      end
      ST_EVSE_SUSP: begin
        if (flt) res.status_reason = RS_FAULT;
        else if (ph == PH_CHARGE) res.status_reason = RS_START;
        else if (ph == PH_FINISH) res.clear_auth = 1'b1;
        else if (ph == PH_FAULT_AB) res.status_reason = RS_FAULT;
      end
      ST_FINISHING: begin
        res.stop_order = order;
        if (order) res.stop_reason = SR_CAR;
        if (flt) res.status_reason = RS_FAULT;
        else if (!plug) begin
          res.return_to_wait = 1'b1;
          res.clear_auth     = 1'b1;
        end
      end
      ST_RESERVED, ST_UNAVAILABLE: res.stop_order = 1'b0;
      ST_FAULTED: begin
        res.clear_auth = 1'b1;
        res.stop_order = order;
        if (order) begin
          if (item.estop_fault) res.stop_reason = SR_EMERGENCY;
          else if (item.outside_volt_high) res.stop_reason = SR_CAR_RUNNING;
          else if (item.door_open) res.stop_reason = SR_DOOR;
          else res.stop_reason = SR_FAULT;
        end
        if (!flt && !plug && ph != PH_WAIT) res.return_to_wait = 1'b1;
      end
      default: res.stop_order = 1'b0;
    endcase

    // LED follows the state held at the start of the tick
    case (cur_state)
      ST_AVAILABLE:   begin res.led_color = LED_GREEN;  res.led_pattern = PAT_STEADY;  end
      ST_PREPARING:   begin res.led_color = LED_BLUE;   res.led_pattern = PAT_BLINK;   end
      ST_CHARGING:    begin res.led_color = LED_BLUE;   res.led_pattern = PAT_BREATHE; end
      ST_EV_SUSP:     begin res.led_color = LED_BLUE;   res.led_pattern = PAT_BLINK;   end
      ST_EVSE_SUSP:   begin res.led_color = LED_BLUE;   res.led_pattern = PAT_BLINK;   end
      ST_FINISHING:   begin res.led_color = LED_BLUE;   res.led_pattern = PAT_STEADY;  end
      ST_RESERVED:    begin res.led_color = LED_BLUE;   res.led_pattern = PAT_BLINK;   end
      ST_UNAVAILABLE: begin res.led_color = LED_YELLOW; res.led_pattern = PAT_STEADY;  end
      ST_FAULTED:     begin res.led_color = LED_RED;    res.led_pattern = PAT_STEADY;  end
      default:        begin res.led_color = LED_KEEP;   res.led_pattern = PAT_STEADY;  end
    endcase

    // unknown connector: echo the index, leave the LED alone, report nothing
    if (!in_range) begin
      res           = '0;
      res.gun_out   = item.gun;
      res.work_state    = ST_SELF_CHECK;
      res.status_reason = RS_NONE;
      res.stop_reason   = SR_DEFAULT;
      res.led_color     = LED_KEEP;
      res.led_pattern   = PAT_STEADY;
    end
  end

endmodule

>>> bench/ccsm_result_checker.sv
// Checker: predicts each connector tick and compares it with the result beats.
module ccsm_result_checker import ccsm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_stall,
  input  ccsm_item_t   tick_in,
  input  logic         out_valid,
  input  logic         out_stall,
  input  ccsm_result_t res_out,
  output int           errors,
  output int           pending
);

  ccsm_result_t results_due[$];
  work_state_t  conn_state [NUM_GUNS];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Result of one tick; work_state carries the connector's next state.
  function automatic ccsm_result_t predict_tick(ccsm_item_t t, work_state_t cur);
    ccsm_result_t r;
    work_state_t  nxt;
    r = '0;
    r.gun_out = t.gun;
    if (int'(t.gun) >= NUM_GUNS) begin
      r.led_color = LED_KEEP;
      return r;
    end
    nxt = cur;

    // LED follows the state held at the start of the tick
    case (cur)
      ST_AVAILABLE: begin
        r.led_color = LED_GREEN;  r.led_pattern = PAT_STEADY;
      end
      ST_PREPARING, ST_EV_SUSP, ST_EVSE_SUSP, ST_RESERVED: begin
        r.led_color = LED_BLUE;   r.led_pattern = PAT_BLINK;
      end
      ST_CHARGING: begin
        r.led_color = LED_BLUE;   r.led_pattern = PAT_BREATHE;
      end
      ST_FINISHING: begin
        r.led_color = LED_BLUE;   r.led_pattern = PAT_STEADY;
      end
      ST_UNAVAILABLE: begin
        r.led_color = LED_YELLOW; r.led_pattern = PAT_STEADY;
      end
      ST_FAULTED: begin
        r.led_color = LED_RED;    r.led_pattern = PAT_STEADY;
      end
      default: begin
        r.led_color = LED_KEEP;   r.led_pattern = PAT_STEADY;
      end
    endcase

    case (cur)
      ST_AVAILABLE: begin
        if (t.order_running) begin
          r.stop_order = 1'b1;
          if (t.lock_fault) r.stop_reason = SR_LOCK;
        end
        if (t.fault_present) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (t.plugged) begin
          r.status_reason = RS_PLUG_IN;
          nxt = ST_PREPARING;
        end
      end
      ST_PREPARING: begin
        if (t.fault_present) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (!t.plugged) begin
          r.status_reason = RS_PLUG_OUT;
          nxt = ST_AVAILABLE;
        end else if (t.bms_phase >= PH_CABLE_CK && t.bms_phase != PH_FAULT_AB) begin
          nxt = ST_EVSE_SUSP;
        end
      end
      ST_CHARGING, ST_EV_SUSP: begin
        if (t.fault_present) begin
          r.cst_fault     = (cur == ST_CHARGING);
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (t.ev_paused != (cur == ST_EV_SUSP)) begin
          // pause request flips between charging and EV suspended
          if (cur == ST_CHARGING) nxt = ST_EV_SUSP;
          else nxt = ST_CHARGING;
        end else if (t.bms_phase == PH_FINISH) begin
          r.clear_auth = 1'b1;
          nxt = ST_FINISHING;
        end else if (t.bms_phase == PH_FAULT_AB) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (t.bms_phase == PH_FAULT_C) begin
          nxt = ST_EVSE_SUSP;
        end
      end
      ST_EVSE_SUSP: begin
        if (t.fault_present) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (t.bms_phase == PH_WAIT) begin
          nxt = ST_AVAILABLE;
        end else if (t.bms_phase == PH_CHARGE) begin
          r.status_reason = RS_START;
          nxt = ST_CHARGING;
        end else if (t.bms_phase == PH_FINISH) begin
          r.clear_auth = 1'b1;
          nxt = ST_FINISHING;
        end else if (t.bms_phase == PH_FAULT_AB) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end
      end
      ST_FINISHING: begin
        if (t.order_running) begin
          r.stop_order  = 1'b1;
          r.stop_reason = SR_CAR;
        end
        if (t.fault_present) begin
          r.status_reason = RS_FAULT;
          nxt = ST_FAULTED;
        end else if (!t.plugged) begin
          r.return_to_wait = 1'b1;
          r.clear_auth     = 1'b1;
          nxt = ST_AVAILABLE;
        end
      end
      ST_RESERVED, ST_UNAVAILABLE: ;
      ST_FAULTED: begin
        r.clear_auth = 1'b1;
        if (t.order_running) begin
          r.stop_order = 1'b1;
          if (t.estop_fault) r.stop_reason = SR_EMERGENCY;
          else if (t.outside_volt_high) r.stop_reason = SR_CAR_RUNNING;
          else if (t.door_open) r.stop_reason = SR_DOOR;
          else r.stop_reason = SR_FAULT;
        end
        if (!t.fault_present) begin
          if (t.plugged) begin
            if (t.bms_phase != PH_FINISH) nxt = ST_PREPARING;
            else nxt = ST_FINISHING;
          end else begin
            r.return_to_wait = (t.bms_phase != PH_WAIT);
            nxt = ST_AVAILABLE;
          end
        end
      end
      default: begin
        if (t.lock_check_ok) nxt = ST_AVAILABLE;
      end
    endcase

    r.work_state    = nxt;
    r.state_changed = (nxt != cur);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ccsm_result_t want;
    if (rst) begin
      results_due.delete();
      foreach (conn_state[i]) conn_state[i] = ST_SELF_CHECK;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result beat with no tick outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("gun_out", 4'(res_out.gun_out), 4'(want.gun_out));
          check_field("work_state", 4'(res_out.work_state), 4'(want.work_state));
          check_field("state_changed", 4'(res_out.state_changed),
                      4'(want.state_changed));
          check_field("status_reason", 4'(res_out.status_reason),
                      4'(want.status_reason));
          check_field("stop_order", 4'(res_out.stop_order), 4'(want.stop_order));
          check_field("stop_reason", 4'(res_out.stop_reason), 4'(want.stop_reason));
          check_field("clear_auth", 4'(res_out.clear_auth), 4'(want.clear_auth));
          check_field("return_to_wait", 4'(res_out.return_to_wait),
                      4'(want.return_to_wait));
          check_field("cst_fault", 4'(res_out.cst_fault), 4'(want.cst_fault));
          check_field("led_color", 4'(res_out.led_color), 4'(want.led_color));
          check_field("led_pattern", 4'(res_out.led_pattern), 4'(want.led_pattern));
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_tick(tick_in, conn_state[tick_in.gun]);
        if (int'(tick_in.gun) < NUM_GUNS) conn_state[tick_in.gun] = want.work_state;
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

>>> bench/charger_connector_state_machine_core_tb.sv
// Testbench top: drives connector ticks into the core and gives the verdict.
module charger_connector_state_machine_core_tb;
  import ccsm_pkg::*;

  localparam logic [2:0] PH_HANDSHAKE = 3'd1;
  localparam logic [2:0] PH_UNLISTED  = 3'd7;
  localparam int RANDOM_TICKS = 950;
  localparam int LONG_HOLD    = 80;

  typedef enum logic [2:0] {
    SS_IDLE, SS_PLUG, SS_PRECHARGE, SS_CHARGE, SS_FINISH, SS_UNPLUG
  } session_stage_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       out_stall = 1'b0;
  ccsm_item_t drv       = '0;

  logic       in_stall;
  logic       out_valid;
  logic       gun_out;
  logic [3:0] work_state;
  logic       state_changed;
  logic [2:0] status_reason;
  logic       stop_order;
  logic [2:0] stop_reason;
  logic       clear_auth;
  logic       return_to_wait;
  logic       cst_fault;
  logic [2:0] led_color;
  logic [1:0] led_pattern;

  int errors;
  int pending;
  int sent       = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  charger_connector_state_machine_core u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .gun               (drv.gun),
    .fault_present     (drv.fault_present),
    .plugged           (drv.plugged),
    .bms_phase         (drv.bms_phase),
    .ev_paused         (drv.ev_paused),
    .order_running     (drv.order_running),
    .lock_check_ok     (drv.lock_check_ok),
    .lock_fault        (drv.lock_fault),
    .estop_fault       (drv.estop_fault),
    .outside_volt_high (drv.outside_volt_high),
    .door_open         (drv.door_open),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .gun_out           (gun_out),
    .work_state        (work_state),
    .state_changed     (state_changed),
    .status_reason     (status_reason),
    .stop_order        (stop_order),
    .stop_reason       (stop_reason),
    .clear_auth        (clear_auth),
    .return_to_wait    (return_to_wait),
    .cst_fault         (cst_fault),
    .led_color         (led_color),
    .led_pattern       (led_pattern)
  );

  ccsm_result_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tick_in   (drv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   ({gun_out, work_state, state_changed, status_reason, stop_order,
                 stop_reason, clear_auth, return_to_wait, cst_fault, led_color,
                 led_pattern}),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic ccsm_item_t mk_tick(bit g, bit flt, bit plug, logic [2:0] ph,
                                         bit pause, bit order, bit lock_ok, bit lock_f,
                                         bit estop, bit ovh, bit door);
    return {g, flt, plug, ph, pause, order, lock_ok, lock_f, estop, ovh, door};
  endfunction

  // Offer one beat; often open a gap between bursts, otherwise keep valid high.
  task automatic send_tick(ccsm_item_t t);
    @(negedge clk);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 100);
      else burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    drv      <= t;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  initial begin : receiver
    int weight;
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      weight = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(negedge clk);
        // hold off once for a long stretch so the core backs up into its input
        if (!held && sent >= 400) begin
          held = 1'b1;
          hold = LONG_HOLD;
        end
        if (hold > 0) begin
          hold--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= ($urandom_range(0, 3) < weight);
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    ccsm_item_t                    t;
    logic [31:0]                   raw;
    session_stage_t                stage      [NUM_GUNS];
    int                            stage_left [NUM_GUNS];
    int                            fault_left [NUM_GUNS];
    int                            g;

    foreach (stage[i]) begin
      stage[i]      = SS_IDLE;
      stage_left[i] = 1;
      fault_left[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // self-check holds until the lock check passes
    send_tick(mk_tick(0, 0, 0, PH_WAIT,      0, 0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 1, PH_UNLISTED,  1, 1, 0, 1, 1, 1, 1));
    send_tick(mk_tick(0, 0, 0, PH_WAIT,      0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, PH_WAIT,      0, 1, 1, 1, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_HANDSHAKE, 0, 1, 1, 0, 0, 0, 0));
    // unlisted phase counts as past cable check
    send_tick(mk_tick(0, 0, 1, PH_UNLISTED,  0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_CHARGE,    0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_CHARGE,    1, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_FAULT_C,   1, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_CHARGE,    0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_FINISH,    0, 0, 1, 0, 0, 0, 0));
    // finishing while plugged holds its state
    send_tick(mk_tick(0, 0, 1, PH_FINISH,    0, 1, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, PH_HANDSHAKE, 0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 1, PH_WAIT,      0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 1, 1, PH_WAIT,      0, 0, 1, 0, 0, 0, 0));
    // stop reason priority while faulted
    send_tick(mk_tick(0, 1, 1, PH_WAIT,      0, 1, 1, 0, 1, 1, 1));
    send_tick(mk_tick(0, 1, 1, PH_WAIT,      0, 1, 1, 0, 0, 1, 1));
    send_tick(mk_tick(0, 0, 1, PH_FINISH,    0, 1, 1, 0, 0, 0, 1));
    send_tick(mk_tick(0, 1, 1, PH_FINISH,    0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(0, 0, 0, PH_FAULT_AB,  0, 1, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 0, 0, PH_WAIT,      0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 0, 1, PH_HANDSHAKE, 0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 0, 1, PH_CABLE_CK,  0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 0, 1, PH_CHARGE,    0, 0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(1, 1, 1, PH_CHARGE,    0, 0, 1, 0, 0, 0, 0));

    // mostly charging sessions per connector, with faults and some raw noise
    repeat (RANDOM_TICKS) begin
      g = $urandom_range(0, NUM_GUNS - 1);
      if ($urandom_range(0, 4) == 0) begin
        raw = $urandom;
        t   = raw[$bits(ccsm_item_t)-1:0];
      end else begin
        t                   = '0;
        t.gun               = 1'(g);
        t.lock_check_ok     = ($urandom_range(0, 7) != 0);
        t.order_running     = 1'($urandom_range(0, 1));
        t.lock_fault        = 1'($urandom_range(0, 1));
        t.estop_fault       = 1'($urandom_range(0, 1));
        t.outside_volt_high = 1'($urandom_range(0, 1));
        t.door_open         = 1'($urandom_range(0, 1));
        if (fault_left[g] == 0 && $urandom_range(0, 24) == 0)
          fault_left[g] = $urandom_range(1, 3);
        t.fault_present = (fault_left[g] != 0);
        if (fault_left[g] != 0) fault_left[g]--;
        t.plugged = (stage[g] != SS_IDLE && stage[g] != SS_UNPLUG);
        case (stage[g])
          SS_IDLE:      t.bms_phase = PH_WAIT;
          SS_PLUG:      t.bms_phase = PH_HANDSHAKE;
          SS_PRECHARGE: t.bms_phase = PH_CABLE_CK;
          SS_CHARGE: begin
            t.ev_paused = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 15))
              0:       t.bms_phase = PH_FAULT_AB;
              1:       t.bms_phase = PH_FAULT_C;
              default: t.bms_phase = PH_CHARGE;
            endcase
          end
          SS_FINISH: begin
            t.ev_paused = 1'($urandom_range(0, 1));
            t.bms_phase = PH_FINISH;
          end
          default: t.bms_phase = 3'($urandom_range(0, 7));
        endcase
        // advance the session once this stage has run its ticks
        if (stage_left[g] > 1) begin
          stage_left[g]--;
        end else begin
          if (stage[g] == SS_UNPLUG) stage[g] = SS_IDLE;
          else stage[g] = session_stage_t'(stage[g] + 1);
          if (stage[g] == SS_CHARGE) stage_left[g] = $urandom_range(3, 12);
          else stage_left[g] = $urandom_range(1, 3);
        end
      end
      send_tick(t);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
